// ===== rtl/core/margolus_block_diffusion_unit_macros.svh =====
// assertion helpers for the margolus block diffusion unit
`ifndef MARGOLUS_BLOCK_DIFFUSION_UNIT_MACROS_SVH
`define MARGOLUS_BLOCK_DIFFUSION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mbd_pkg.sv =====
`default_nettype none

package mbd_pkg;

    localparam int GRID_X_DEF    = 64;
    localparam int GRID_Y_DEF    = 64;
    localparam int CELL_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] BORDER_ABSORB = 2'd0;
    localparam logic [1:0] BORDER_TORUS  = 2'd1;

    localparam logic [6:0]  WIDTH_RST  = 7'd50;
    localparam logic [6:0]  HEIGHT_RST = 7'd50;
    localparam logic [1:0]  BORDER_RST = BORDER_TORUS;
    localparam logic        OBST_RST   = 1'b0;
    localparam logic [31:0] SEED_RST   = 32'd1;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_OBST,
        KIND_SWEEP
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_BORDER,
        CFG_OBST,
        CFG_SEED
    } t_cfg_idx;

    typedef struct packed {
        logic [6:0] width;
        logic [6:0] height;
        logic [1:0] border;
        logic       obst_on;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic step_block;
    } t_walk_cmd;

    typedef struct packed {
        logic in_area;
        logic last_block;
        logic empty;
    } t_walk_info;

    typedef struct packed {
        logic       valid;
        logic [7:0] read_value;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/mbd_ram.sv =====
`default_nettype none

module mbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/mbd_walker.sv =====
`default_nettype none

module mbd_walker #(
    parameter int GRID_X = mbd_pkg::GRID_X_DEF,
    parameter int GRID_Y = mbd_pkg::GRID_Y_DEF,
    localparam int AW = $clog2(GRID_X * GRID_Y)
) (
    input  wire logic                   i_clk,
    input  wire mbd_pkg::t_cfg          i_cfg,
    input  wire logic                   i_phase,
    input  wire mbd_pkg::t_walk_cmd     i_cmd,
    input  wire logic [1:0]             i_corner,
    output logic      [AW-1:0]          o_addr,
    output mbd_pkg::t_walk_info         o_info
);

    localparam logic [6:0] X_CAP = (GRID_X > 127) ? 7'd127 : 7'(GRID_X);
    localparam logic [6:0] Y_CAP = (GRID_Y > 127) ? 7'd127 : 7'(GRID_Y);

    logic [6:0]        w_eff;
    logic [6:0]        h_eff;
    logic signed [7:0] w_s;
    logic signed [7:0] h_s;
    logic signed [7:0] sx;
    logic signed [7:0] ex;
    logic signed [7:0] sy;
    logic signed [7:0] ey;
    logic signed [7:0] r_ox;
    logic signed [7:0] r_oy;
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic              wrap;
    logic              col_end;
    logic              row_end;

    assign w_eff = ((i_cfg.width > X_CAP) ? X_CAP : i_cfg.width) & 7'h7E;
    assign h_eff = ((i_cfg.height > Y_CAP) ? Y_CAP : i_cfg.height) & 7'h7E;
    assign w_s   = signed'({1'b0, w_eff});
    assign h_s   = signed'({1'b0, h_eff});
    assign wrap  = (i_cfg.border == mbd_pkg::BORDER_TORUS);

    // block origins for the current tiling
    always_comb begin
        if (i_phase) begin
            sx = 8'sd0;
            ex = w_s - 8'sd2;
            sy = 8'sd0;
            ey = h_s - 8'sd2;
        end else if (i_cfg.border == mbd_pkg::BORDER_ABSORB) begin
            sx = -8'sd1;
            ex = w_s - 8'sd1;
            sy = -8'sd1;
            ey = h_s - 8'sd1;
        end else if (wrap) begin
            sx = -8'sd1;
            ex = w_s - 8'sd3;
            sy = -8'sd1;
            ey = h_s - 8'sd3;
        end else begin
            sx = 8'sd1;
            ex = w_s - 8'sd3;
            sy = 8'sd1;
            ey = h_s - 8'sd3;
        end
    end

    assign row_end = (r_oy + 8'sd2 > ey);
    assign col_end = (r_ox + 8'sd2 > ex);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ox <= sx;
            r_oy <= sy;
        end else if (i_cmd.step_block) begin
            if (row_end) begin
                r_oy <= sy;
                r_ox <= r_ox + 8'sd2;
            end else begin
                r_oy <= r_oy + 8'sd2;
            end
        end
    end

    // corners a, b, c, d go clockwise from the origin
    always_comb begin
        cx = (i_corner[0] ^ i_corner[1]) ? r_ox + 8'sd1 : r_ox;
        cy = i_corner[1] ? r_oy + 8'sd1 : r_oy;
        if (wrap && cx < 8'sd0) begin
            cx = cx + w_s;
        end
        if (wrap && cx >= w_s) begin
            cx = cx - w_s;
        end
        if (wrap && cy < 8'sd0) begin
            cy = cy + h_s;
        end
        if (wrap && cy >= h_s) begin
            cy = cy - h_s;
        end
    end

    assign o_info.in_area    = (cx >= 8'sd0) && (cx < w_s) && (cy >= 8'sd0) && (cy < h_s);
    assign o_info.last_block = row_end && col_end;
    assign o_info.empty      = (w_eff < 7'd2) || (h_eff < 7'd2) || (sx > ex) || (sy > ey);
    assign o_addr = o_info.in_area ? AW'(cy[6:0]) * AW'(GRID_X) + AW'(cx[6:0]) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/mbd_ctrl.sv =====
`default_nettype none
`include "margolus_block_diffusion_unit_macros.svh"

module mbd_ctrl #(
    parameter int GRID_X    = mbd_pkg::GRID_X_DEF,
    parameter int GRID_Y    = mbd_pkg::GRID_Y_DEF,
    parameter int CELL_BITS = mbd_pkg::CELL_BITS_DEF,
    localparam int DEPTH = GRID_X * GRID_Y,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_item_valid,
    output logic                       o_item_ready,
    input  wire logic [1:0]            i_kind,
    input  wire logic [5:0]            i_x,
    input  wire logic [5:0]            i_y,
    input  wire logic [7:0]            i_value,
    input  wire mbd_pkg::t_cfg         i_cfg,
    input  wire logic                  i_seed_load,
    input  wire logic [31:0]           i_seed,
    output logic                       o_phase,
    output mbd_pkg::t_walk_cmd         o_walk_cmd,
    output logic      [1:0]            o_corner,
    input  wire logic [AW-1:0]         i_walk_addr,
    input  wire mbd_pkg::t_walk_info   i_walk_info,
    output logic      [AW-1:0]         o_waddr,
    output logic                       o_cell_we,
    output logic      [CELL_BITS-1:0]  o_cell_wdata,
    output logic                       o_obst_we,
    output logic                       o_obst_wdata,
    output logic      [AW-1:0]         o_raddr,
    input  wire logic [CELL_BITS-1:0]  i_cell_rdata,
    input  wire logic                  i_obst_rdata,
    output mbd_pkg::t_result           o_result,
    input  wire logic                  i_result_ready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SW_RD,
        ST_SW_CAP,
        ST_SW_ROT,
        ST_SW_WR,
        ST_RESP
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_phase;
    logic [31:0]          r_lfsr;
    logic [1:0]           r_k;
    logic                 r_cap_en;
    logic [1:0]           r_cap_k;
    logic                 r_blocked;
    logic                 r_dir;
    logic                 r_ok;
    logic [7:0]           r_rd;
    logic [3:0]           r_in;
    logic [CELL_BITS-1:0] r_v [4];

    logic [AW-1:0]        item_addr;
    logic                 item_ok;
    mbd_pkg::t_kind       kind;
    logic [31:0]          lfsr_next;
    logic                 blk_end;
    logic                 sweep_end;

    assign kind      = mbd_pkg::t_kind'(i_kind);
    assign item_ok   = (32'(i_x) < GRID_X) && (32'(i_y) < GRID_Y);
    assign item_addr = AW'(i_y) * AW'(GRID_X) + AW'(i_x);
    assign lfsr_next = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? mbd_pkg::LFSR_TAPS : 32'd0);

    assign blk_end   = (r_state == ST_SW_ROT && r_blocked) || (r_state == ST_SW_WR && r_k == 2'd3);
    assign sweep_end = (blk_end && i_walk_info.last_block)
                    || (r_state == ST_IDLE && i_item_valid && kind == mbd_pkg::KIND_SWEEP
                        && i_walk_info.empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_phase    <= 1'b0;
            r_lfsr     <= mbd_pkg::SEED_RST;
            r_k        <= 2'd0;
            r_cap_en   <= 1'b0;
            r_blocked  <= 1'b0;
        end else begin
            if (r_cap_en) begin
                r_v[r_cap_k] <= r_in[r_cap_k] ? i_cell_rdata : '0;
                if (r_in[r_cap_k] && i_obst_rdata && i_cfg.obst_on) begin
                    r_blocked <= 1'b1;
                end
            end
            r_cap_en <= (r_state == ST_SW_RD);
            if (sweep_end) begin
                r_phase <= ~r_phase;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: if (i_item_valid) begin
                    r_rd <= '0;
                    unique case (kind)
                        mbd_pkg::KIND_READ: begin
                            r_ok    <= item_ok;
                            r_state <= ST_READ;
                        end
                        mbd_pkg::KIND_SWEEP: begin
                            if (i_walk_info.empty) begin
                                r_state <= ST_RESP;
                            end else begin
                                r_k       <= 2'd0;
                                r_blocked <= 1'b0;
                                r_state   <= ST_SW_RD;
                            end
                        end
                        default: r_state <= ST_RESP;
                    endcase
                end
                ST_READ: begin
                    r_rd    <= r_ok ? 8'(i_cell_rdata) : 8'd0;
                    r_state <= ST_RESP;
                end
                ST_SW_RD: begin
                    r_in[r_k] <= i_walk_info.in_area;
                    r_cap_k   <= r_k;
                    r_k       <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= ST_SW_CAP;
                    end
                end
                ST_SW_CAP: r_state <= ST_SW_ROT;
                ST_SW_ROT: begin
                    if (r_blocked) begin
                        r_k       <= 2'd0;
                        r_blocked <= 1'b0;
                        r_state   <= i_walk_info.last_block ? ST_RESP : ST_SW_RD;
                    end else begin
                        r_dir   <= r_lfsr[0];
                        r_lfsr  <= lfsr_next;
                        r_k     <= 2'd0;
                        r_state <= ST_SW_WR;
                    end
                end
                ST_SW_WR: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_blocked <= 1'b0;
                        r_state   <= i_walk_info.last_block ? ST_RESP : ST_SW_RD;
                    end
                end
                ST_RESP: if (i_result_ready) begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase

            if (i_seed_load) begin
                r_lfsr <= i_seed;
            end
        end
    end

    always_comb begin
        o_cell_we    = 1'b0;
        o_obst_we    = 1'b0;
        o_waddr      = i_walk_addr;
        o_cell_wdata = r_dir ? r_v[r_k - 2'd1] : r_v[r_k + 2'd1];
        o_obst_wdata = 1'b0;
        o_raddr      = item_addr;
        o_walk_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cell_we    = 1'b1;
                o_obst_we    = 1'b1;
                o_waddr      = r_clr_addr;
                o_cell_wdata = '0;
            end
            ST_IDLE: begin
                o_waddr      = item_addr;
                o_cell_wdata = i_value[CELL_BITS-1:0];
                o_obst_wdata = i_value[0];
                o_cell_we    = i_item_valid && item_ok && kind == mbd_pkg::KIND_WRITE;
                o_obst_we    = i_item_valid && item_ok && kind == mbd_pkg::KIND_OBST;
                o_walk_cmd.start = i_item_valid && kind == mbd_pkg::KIND_SWEEP;
            end
            ST_SW_RD: o_raddr = i_walk_addr;
            ST_SW_WR: o_cell_we = r_in[r_k];
            default: ;
        endcase
        o_walk_cmd.step_block = blk_end && !i_walk_info.last_block;
    end

    assign o_item_ready        = (r_state == ST_IDLE);
    assign o_result.valid      = (r_state == ST_RESP);
    assign o_result.read_value = r_rd;
    assign o_phase             = r_phase;
    assign o_corner            = r_k;

    `MBD_ASSERT_NEXT(a_lfsr_hold, i_clk, i_rst_n, (!i_seed_load && r_state != ST_SW_ROT), $stable(r_lfsr), "direction lfsr moved outside a rotation")
    `MBD_ASSERT_SAME(a_blocked_no_write, i_clk, i_rst_n, (r_state == ST_SW_WR), !r_blocked, "blocked block written back")
    `MBD_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !sweep_end, $stable(r_phase), "phase flipped outside a sweep end")

endmodule

`default_nettype wire

// ===== rtl/core/margolus_block_diffusion_unit.sv =====
// requests: writes and obstacles go from idle to the result, reads through a read state first
// sweep: each 2x2 block that turns takes 4 reads, capture, rotate and 4 write-backs;
// a block held by an obstacle skips the write-backs; one request at a time
// reset: synchronous active low; afterwards both memories are cleared before the first
// request is taken; config writes are taken meanwhile
`default_nettype none

module margolus_block_diffusion_unit #(
    parameter int GRID_X    = mbd_pkg::GRID_X_DEF,
    parameter int GRID_Y    = mbd_pkg::GRID_Y_DEF,
    parameter int CELL_BITS = mbd_pkg::CELL_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [23:0]                    i_s_tdata,   // x_pos, y_pos, value
    input  wire logic [1:0]                     i_s_tuser,   // kind
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [15:0]                    o_m_tdata,   // read_value, done_res
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);

    mbd_pkg::t_cfg         r_cfg;
    logic                  r_out_valid;
    logic [7:0]            r_out_rd;

    logic                  seed_load;
    logic                  phase;
    mbd_pkg::t_walk_cmd    walk_cmd;
    mbd_pkg::t_walk_info   walk_info;
    logic [1:0]            corner;
    logic [AW-1:0]         walk_addr;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic                  cell_we;
    logic [CELL_BITS-1:0]  cell_wdata;
    logic [CELL_BITS-1:0]  cell_rdata;
    logic                  obst_we;
    logic                  obst_wdata;
    logic                  obst_rdata;
    mbd_pkg::t_result      result;
    logic                  result_ready;

    assign o_cfg_ready = 1'b1;
    assign seed_load   = i_cfg_valid && (i_cfg_index == mbd_pkg::CFG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= mbd_pkg::WIDTH_RST;
            r_cfg.height  <= mbd_pkg::HEIGHT_RST;
            r_cfg.border  <= mbd_pkg::BORDER_RST;
            r_cfg.obst_on <= mbd_pkg::OBST_RST;
        end else if (i_cfg_valid) begin
            unique case (mbd_pkg::t_cfg_idx'(i_cfg_index))
                mbd_pkg::CFG_WIDTH:  r_cfg.width   <= i_cfg_data[6:0];
                mbd_pkg::CFG_HEIGHT: r_cfg.height  <= i_cfg_data[6:0];
                mbd_pkg::CFG_BORDER: r_cfg.border  <= i_cfg_data[1:0];
                mbd_pkg::CFG_OBST:   r_cfg.obst_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // output register parts the result from the engine
    assign result_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid && result_ready) begin
            r_out_valid <= 1'b1;
            r_out_rd    <= result.read_value;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, 1'b1, r_out_rd};

    mbd_ctrl #(
        .GRID_X    (GRID_X),
        .GRID_Y    (GRID_Y),
        .CELL_BITS (CELL_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_s_tvalid),
        .o_item_ready   (o_s_tready),
        .i_kind         (i_s_tuser),
        .i_x            (i_s_tdata[5:0]),
        .i_y            (i_s_tdata[11:6]),
        .i_value        (i_s_tdata[19:12]),
        .i_cfg          (r_cfg),
        .i_seed_load    (seed_load),
        .i_seed         (i_cfg_data),
        .o_phase        (phase),
        .o_walk_cmd     (walk_cmd),
        .o_corner       (corner),
        .i_walk_addr    (walk_addr),
        .i_walk_info    (walk_info),
        .o_waddr        (waddr),
        .o_cell_we      (cell_we),
        .o_cell_wdata   (cell_wdata),
        .o_obst_we      (obst_we),
        .o_obst_wdata   (obst_wdata),
        .o_raddr        (raddr),
        .i_cell_rdata   (cell_rdata),
        .i_obst_rdata   (obst_rdata),
        .o_result       (result),
        .i_result_ready (result_ready)
    );

    mbd_walker #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_walker (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_phase  (phase),
        .i_cmd    (walk_cmd),
        .i_corner (corner),
        .o_addr   (walk_addr),
        .o_info   (walk_info)
    );

    mbd_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (waddr),
        .i_wdata (cell_wdata),
        .i_raddr (raddr),
        .o_rdata (cell_rdata)
    );

    mbd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_obst_ram (
        .i_clk   (i_clk),
        .i_we    (obst_we),
        .i_waddr (waddr),
        .i_wdata (obst_wdata),
        .i_raddr (raddr),
        .o_rdata (obst_rdata)
    );

endmodule

`default_nettype wire
